>>> rtl/hbte_pkg.sv
// ============================================================================
// hbte_pkg: shared types and helpers for the hit-map binary-tree encoder
// Node codes and the field widths used by the encoder pipeline.
// ============================================================================
package hbte_pkg;

    localparam int MaskWidth   = 16;
    localparam int CodeWidth   = 30;
    localparam int LengthWidth = 5;
    localparam int NumPairs    = 8;
    localparam int NumLeaves   = 16;

    // Two-bit node codes for a node with its first child hit, and the empty code.
    localparam logic [1:0] CodeFirstOnly = 2'h2;
    localparam logic [1:0] CodeBoth      = 2'h3;
    localparam logic [1:0] CodeNone      = 2'h0;

    // One emitted node: code bits (LSB first) and how many of them count.
    typedef struct packed {
        logic [1:0] val;
        logic [1:0] len;
    } node_t;

    // A node emits nothing for no children, a single zero bit for only the
    // second child, and two bits otherwise.
    function automatic node_t node_code(input logic first, input logic second);
        node_t n;
        begin
            n.val = CodeNone;
            n.len = 2'd0;
            if (first)
            begin
                n.val = second ? CodeBoth : CodeFirstOnly;
                n.len = 2'd2;
            end
            else if (second)
            begin
                n.val = CodeNone;
                n.len = 2'd1;
            end
            return n;
        end
    endfunction

endpackage

>>> rtl/hitmap_binary_tree_encoder.sv
// ============================================================================
// hitmap_binary_tree_encoder: binary-tree code for a 4x4 quarter-core hit map
// Turns a 16-pixel hit mask into a packed variable-length tree code and its
// length, through a six-stage pipeline that takes one mask every cycle.
// ============================================================================
//
//  Channel   Ports                          Handshake
//  -------   -----------------------------  ---------------------------------
//  input     hit_mask                       beat taken when start && !busy
//  result    tree_code, code_length         beat shown for one cycle by done
//
// A mask captured at an accepting edge passes through six register stages:
// capture, node codes, three levels of the concatenation tree, and the
// output register behind the last level. Done is high for exactly the cycle
// in which its result shows up on the result ports.
// One mask can enter every cycle; the receiver cannot stall, so busy stays low.
// Reset clears the valid bits of every stage; payload registers are not reset.

module hitmap_binary_tree_encoder (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [hbte_pkg::MaskWidth-1:0]       hit_mask,
    output logic                                 done,
    output logic [hbte_pkg::CodeWidth-1:0]       tree_code,
    output logic [hbte_pkg::LengthWidth-1:0]     code_length
);

    // Valid bits, one per pipeline stage.
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // Stage 0: captured mask.
    logic [hbte_pkg::MaskWidth-1:0] mask_reg;

    // Stage 1: the 15 node codes in emission order, plus one empty leaf so the
    // concatenation tree is a full binary tree.
    hbte_pkg::node_t leaf_reg  [hbte_pkg::NumLeaves];
    hbte_pkg::node_t leaf_next [hbte_pkg::NumLeaves];

    // Stages 2 to 4: partial concatenations, each group holds its code bits
    // packed from bit zero and its length.
    logic [3:0]  g2_val_reg  [8];
    logic [2:0]  g2_len_reg  [8];
    logic [3:0]  g2_val_next [8];
    logic [2:0]  g2_len_next [8];
    logic [7:0]  g3_val_reg  [4];
    logic [3:0]  g3_len_reg  [4];
    logic [7:0]  g3_val_next [4];
    logic [3:0]  g3_len_next [4];
    logic [15:0] g4_val_reg  [2];
    logic [4:0]  g4_len_reg  [2];
    logic [15:0] g4_val_next [2];
    logic [4:0]  g4_len_next [2];

    // Stage 5: output register.
    logic [hbte_pkg::CodeWidth-1:0]   tree_code_reg;
    logic [hbte_pkg::LengthWidth-1:0] code_length_reg;
    logic [hbte_pkg::CodeWidth-1:0]   tree_code_next;
    logic [hbte_pkg::LengthWidth-1:0] code_length_next;

    // Pair, quarter and half flags of the captured mask.
    logic [hbte_pkg::NumPairs-1:0] pair_top;
    logic [hbte_pkg::NumPairs-1:0] pair_bot;
    logic [hbte_pkg::NumPairs-1:0] pair_any;
    logic [3:0]                    quarter_any;
    logic [1:0]                    half_any;

    logic [31:0] final_val;
    logic [5:0]  final_len;

    assign busy = 1'b0;

    // Pair p covers the top pixel at mask bit 14-2p and the bottom one at
    // bit 15-2p.
    always_comb
    begin
        for (int p = 0; p < hbte_pkg::NumPairs; p++)
        begin
            pair_top[p] = mask_reg[14 - 2 * p];
            pair_bot[p] = mask_reg[15 - 2 * p];
            pair_any[p] = pair_top[p] | pair_bot[p];
        end
        for (int q = 0; q < 4; q++)
        begin
            quarter_any[q] = pair_any[2 * q + 1] | pair_any[2 * q];
        end
        for (int h = 0; h < 2; h++)
        begin
            half_any[h] = quarter_any[2 * h + 1] | quarter_any[2 * h];
        end
    end

    // Node codes in emission order: four pairs, the two s3 nodes and the s2
    // node of the first half, the same for the second half, then s1.
    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            leaf_next[p]     = hbte_pkg::node_code(pair_top[p], pair_bot[p]);
            leaf_next[p + 7] = hbte_pkg::node_code(pair_top[p + 4], pair_bot[p + 4]);
        end
        leaf_next[4]  = hbte_pkg::node_code(pair_any[1], pair_any[0]);
        leaf_next[5]  = hbte_pkg::node_code(pair_any[3], pair_any[2]);
        leaf_next[6]  = hbte_pkg::node_code(quarter_any[1], quarter_any[0]);
        leaf_next[11] = hbte_pkg::node_code(pair_any[5], pair_any[4]);
        leaf_next[12] = hbte_pkg::node_code(pair_any[7], pair_any[6]);
        leaf_next[13] = hbte_pkg::node_code(quarter_any[3], quarter_any[2]);
        leaf_next[14] = hbte_pkg::node_code(half_any[1], half_any[0]);
        leaf_next[15] = hbte_pkg::node_code(1'b0, 1'b0);
    end

    // Each tree level appends the right group behind the left one by shifting
    // it up by the left group's length.
    always_comb
    begin
        for (int g = 0; g < 8; g++)
        begin
            g2_val_next[g] = {2'b00, leaf_reg[2 * g].val}
                           | ({2'b00, leaf_reg[2 * g + 1].val} << leaf_reg[2 * g].len);
            g2_len_next[g] = {1'b0, leaf_reg[2 * g].len} + {1'b0, leaf_reg[2 * g + 1].len};
        end
        for (int g = 0; g < 4; g++)
        begin
            g3_val_next[g] = {4'h0, g2_val_reg[2 * g]}
                           | ({4'h0, g2_val_reg[2 * g + 1]} << g2_len_reg[2 * g]);
            g3_len_next[g] = {1'b0, g2_len_reg[2 * g]} + {1'b0, g2_len_reg[2 * g + 1]};
        end
        for (int g = 0; g < 2; g++)
        begin
            g4_val_next[g] = {8'h00, g3_val_reg[2 * g]}
                           | ({8'h00, g3_val_reg[2 * g + 1]} << g3_len_reg[2 * g]);
            g4_len_next[g] = {1'b0, g3_len_reg[2 * g]} + {1'b0, g3_len_reg[2 * g + 1]};
        end
        // The full code never passes 30 bits, so the top bits of the sum and
        // of the shifted word are always zero.
        final_val        = {16'h0000, g4_val_reg[0]} | ({16'h0000, g4_val_reg[1]} << g4_len_reg[0]);
        final_len        = {1'b0, g4_len_reg[0]} + {1'b0, g4_len_reg[1]};
        tree_code_next   = final_val[hbte_pkg::CodeWidth-1:0];
        code_length_next = final_len[hbte_pkg::LengthWidth-1:0];
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start & ~busy;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Payload registers load only when their stage takes a valid beat.
    always_ff @(posedge clk)
    begin
        if (start & ~busy)
        begin
            mask_reg <= hit_mask;
        end
        if (v0_reg)
        begin
            leaf_reg <= leaf_next;
        end
        if (v1_reg)
        begin
            g2_val_reg <= g2_val_next;
            g2_len_reg <= g2_len_next;
        end
        if (v2_reg)
        begin
            g3_val_reg <= g3_val_next;
            g3_len_reg <= g3_len_next;
        end
        if (v3_reg)
        begin
            g4_val_reg <= g4_val_next;
            g4_len_reg <= g4_len_next;
        end
        if (v4_reg)
        begin
            tree_code_reg   <= tree_code_next;
            code_length_reg <= code_length_next;
        end
    end

    assign done        = v5_reg;
    assign tree_code   = tree_code_reg;
    assign code_length = code_length_reg;

endmodule

>>> sim/hbte_tree_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// hbte_tree_checker: result checker for the hit-map binary-tree encoder
// Watches the mask and result channels, predicts the tree code and length
// of every accepted mask beat, and compares each result beat against the
// oldest prediction still waiting.
// ============================================================================

module hbte_tree_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic [hbte_pkg::MaskWidth-1:0]       hit_mask,
    input  logic                                 done,
    input  logic [hbte_pkg::CodeWidth-1:0]       tree_code,
    input  logic [hbte_pkg::LengthWidth-1:0]     code_length,
    output int                                   codes_in_flight,
    output int                                   mismatch_count
);

    import hbte_pkg::*;

    localparam int ReportLimit = 10;
    localparam int NumNodes    = 15;

    typedef struct packed {
        logic [CodeWidth-1:0]   code;
        logic [LengthWidth-1:0] length;
    } tree_result_t;

    tree_result_t pending_codes[$];

    // Builds the fifteen (first, second) child flag pairs in emission order,
    // then packs the node codes LSB first.
    function automatic tree_result_t encode_hit_tree(input logic [MaskWidth-1:0] mask);
        logic [7:0]          pair_hit;
        logic [3:0]          quad_hit;
        logic [1:0]          half_hit;
        logic [NumNodes-1:0] first_child;
        logic [NumNodes-1:0] second_child;
        logic [31:0]         acc;
        logic [1:0]          node_bits;
        int                  len;
        int                  node;
        int                  base;
        tree_result_t        res;

        for (int p = 0; p < 8; p++)
            pair_hit[p] = mask[14 - 2 * p] | mask[15 - 2 * p];
        for (int q = 0; q < 4; q++)
            quad_hit[q] = pair_hit[2 * q] | pair_hit[2 * q + 1];
        for (int h = 0; h < 2; h++)
            half_hit[h] = quad_hit[2 * h] | quad_hit[2 * h + 1];

        node = 0;
        for (int h = 0; h < 2; h++)
        begin
            base = 4 * h;
            // Four pixel pairs: top pixel is the first child.
            for (int k = 0; k < 4; k++)
            begin
                first_child[node]  = mask[14 - 2 * (base + k)];
                second_child[node] = mask[15 - 2 * (base + k)];
                node++;
            end
            // The s3 nodes list the higher pair first, then the s2 node.
            first_child[node]  = pair_hit[base + 1];
            second_child[node] = pair_hit[base];
            node++;
            first_child[node]  = pair_hit[base + 3];
            second_child[node] = pair_hit[base + 2];
            node++;
            first_child[node]  = quad_hit[2 * h + 1];
            second_child[node] = quad_hit[2 * h];
            node++;
        end
        first_child[node]  = half_hit[1];
        second_child[node] = half_hit[0];

        acc = '0;
        len = 0;
        for (int n = 0; n < NumNodes; n++)
        begin
            if (first_child[n])
            begin
                node_bits = second_child[n] ? CodeBoth : CodeFirstOnly;
                acc = acc | (32'(node_bits) << len);
                len = len + 2;
            end
            else if (second_child[n])
                len = len + 1;
        end

        res.code   = acc[CodeWidth-1:0];
        res.length = len[LengthWidth-1:0];
        return res;
    endfunction

    always @(posedge clk)
    begin
        tree_result_t want;
        if (!rst_n)
        begin
            pending_codes.delete();
            codes_in_flight = 0;
        end
        else
        begin
            if (start && !busy)
                pending_codes = {pending_codes, encode_hit_tree(hit_mask)};

            if (done)
            begin
                if (pending_codes.size() == 0)
                begin
                    if (mismatch_count < ReportLimit)
                        $display("%0t: result beat with nothing expected: code=%h length=%0d",
                                 $realtime, tree_code, code_length);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_codes.pop_front();
                    if (tree_code !== want.code || code_length !== want.length)
                    begin
                        if (mismatch_count < ReportLimit)
                            $display("%0t: mismatch: code exp=%h act=%h length exp=%0d act=%0d",
                                     $realtime, want.code, tree_code, want.length,
                                     code_length);
                        mismatch_count++;
                    end
                end
            end
            codes_in_flight = pending_codes.size();
        end
    end

endmodule

>>> sim/hitmap_binary_tree_encoder_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// hitmap_binary_tree_encoder_tb: testbench for the hit-map tree encoder
// Sends directed and random 16-pixel hit masks in random bursts and lets a
// checker module compare every result beat with its own prediction.
// ============================================================================

module hitmap_binary_tree_encoder_tb;

    import hbte_pkg::*;

    // Number of random mask beats after the directed part.
    localparam int RandomBeats = 1700;
    // A drain is forced every this many random beats.
    localparam int DrainEvery  = 400;
    // Extra cycles after the last result; the pipeline is six stages deep.
    localparam int TailCycles  = 12;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [MaskWidth-1:0]   hit_mask;
    logic                   done;
    logic [CodeWidth-1:0]   tree_code;
    logic [LengthWidth-1:0] code_length;
    int                     codes_in_flight;
    int                     mismatch_count;

    hitmap_binary_tree_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .hit_mask    (hit_mask),
        .done        (done),
        .tree_code   (tree_code),
        .code_length (code_length)
    );

    // The checker sees exactly what the block sees and reports back how many
    // predictions are still waiting and how many beats went wrong.
    hbte_tree_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .hit_mask        (hit_mask),
        .done            (done),
        .tree_code       (tree_code),
        .code_length     (code_length),
        .codes_in_flight (codes_in_flight),
        .mismatch_count  (mismatch_count)
    );

    // 20 ns clock period.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop in case the result channel goes quiet. The slowest correct
    // run ends far sooner, so this leaves a wide margin.
    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Presents one mask beat and returns at the edge where it was taken.
    // The caller keeps start high for back-to-back beats.
    task automatic send_mask(input logic [MaskWidth-1:0] mask);
        start    <= 1'b1;
        hit_mask <= mask;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Lowers start and waits until every predicted result has come back.
    // The count is read at the falling edge, where the checker is settled,
    // and the task returns on a rising edge so driving can carry on.
    task automatic drain_results;
        start <= 1'b0;
        do
            @(negedge clk);
        while (codes_in_flight != 0);
        @(posedge clk);
    endtask

    // Random masks come in several flavors. Uniform masks exercise every
    // node combination; sparse and nearly full masks reach the short codes
    // and the long ones; masks confined to one half leave a whole subtree
    // empty so the s1 node takes its single-child forms.
    function automatic logic [MaskWidth-1:0] random_mask;
        logic [MaskWidth-1:0] m;
        int                   flavor;
        int                   nbits;
        flavor = $urandom_range(0, 7);
        m = MaskWidth'($urandom);
        case (flavor)
            4, 5:
            begin
                m = '0;
                nbits = $urandom_range(1, 3);
                repeat (nbits)
                    m[$urandom_range(0, MaskWidth - 1)] = 1'b1;
                if (flavor == 5)
                    m = ~m;
            end
            6:
                m = m & 16'h00FF;
            7:
                m = m & 16'hFF00;
            default:
                ;
        endcase
        return m;
    endfunction

    initial
    begin
        logic [MaskWidth-1:0] directed_masks[$];
        int                   sent;
        int                   burst;
        int                   gap;

        // Every input is known from time zero; reset is held low before release.
        rst_n    = 1'b0;
        start    = 1'b0;
        hit_mask = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats: the empty mask (a zero-length code still gives a
        // result), the full mask (the longest 30-bit code), each pixel on
        // its own, all-top and all-bottom pixels, and each half or
        // alternating quarter alone.
        directed_masks = {16'h0000, 16'hFFFF};
        for (int b = 0; b < MaskWidth; b++)
            directed_masks = {directed_masks, MaskWidth'(1) << b};
        directed_masks = {directed_masks, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00,
                          16'h0F0F, 16'hF0F0};

        // The directed list goes out back to back, with no gaps at all.
        foreach (directed_masks[i])
            send_mask(directed_masks[i]);
        drain_results();

        // Random part: bursts of random length separated by random gaps.
        // About a quarter of the gaps are zero so long unbroken stretches
        // also occur. Every few hundred beats the sender stops and lets the
        // pipeline empty completely before going on.
        sent = 0;
        while (sent < RandomBeats)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < RandomBeats; i++)
            begin
                send_mask(random_mask());
                sent++;
                if (sent % DrainEvery == 0)
                    drain_results();
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            // Start is only lowered when a real gap follows, so it never
            // gets two assignments in the same time step.
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end

        // Wait for the last results, then a few more cycles in case the
        // block puts out a stray result beat.
        drain_results();
        repeat (TailCycles) @(posedge clk);
        @(negedge clk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/hbte_pkg.sv
rtl/hitmap_binary_tree_encoder.sv
sim/hbte_tree_checker.sv
sim/hitmap_binary_tree_encoder_tb.sv
